// File: design/ir_text_tokenizer_macros.svh
// assertion macros shared by the tokenizer checker
`ifndef IR_TEXT_TOKENIZER_MACROS_SVH
`define IR_TEXT_TOKENIZER_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define ITT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, ignored while reset is high
`define ITT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also covers the reset cycles
`define ITT_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/itt_pkg.sv
// shared types, constants and helper functions of the text tokenizer
package itt_pkg;

   // default sizes
   localparam int KEYWORD_MAX_LEN_DEF     = 8;
   localparam int FRACTION_DIGITS_MAX_DEF = 18;
   localparam int POSITION_WIDTH_DEF      = 32;
   localparam int QUEUE_DEPTH             = 4;
   localparam int KW_TEXT_BYTES           = 8;
   localparam int NUM_KW                  = 69;
   localparam int RUN_SLOTS               = 3;

   // token kinds
   localparam logic [6:0] KIND_EOF      = 7'd0;
   localparam logic [6:0] KIND_ILLEGAL  = 7'd1;
   localparam logic [6:0] KIND_IDENT    = 7'd2;
   localparam logic [6:0] KIND_GLOBAL   = 7'd3;
   localparam logic [6:0] KIND_LOCAL    = 7'd4;
   localparam logic [6:0] KIND_LABEL    = 7'd5;
   localparam logic [6:0] KIND_INT      = 7'd6;
   localparam logic [6:0] KIND_FLOAT    = 7'd7;
   localparam logic [6:0] KIND_STRING   = 7'd8;
   localparam logic [6:0] KIND_EQUAL    = 7'd9;
   localparam logic [6:0] KIND_COMMA    = 7'd10;
   localparam logic [6:0] KIND_COLON    = 7'd11;
   localparam logic [6:0] KIND_LBRACE   = 7'd12;
   localparam logic [6:0] KIND_RBRACE   = 7'd13;
   localparam logic [6:0] KIND_LBRACKET = 7'd14;
   localparam logic [6:0] KIND_RBRACKET = 7'd15;
   localparam logic [6:0] KIND_LPAREN   = 7'd16;
   localparam logic [6:0] KIND_RPAREN   = 7'd17;
   localparam logic [6:0] KIND_LANGLE   = 7'd18;
   localparam logic [6:0] KIND_RANGLE   = 7'd19;
   localparam logic [6:0] KIND_ELLIPSIS = 7'd20;
   localparam logic [6:0] KIND_KW_BASE  = 7'd21;

   // character codes
   localparam logic [7:0] CH_NUL      = 8'h00;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_DOLLAR   = 8'h24;
   localparam logic [7:0] CH_PERCENT  = 8'h25;
   localparam logic [7:0] CH_LPAREN   = 8'h28;
   localparam logic [7:0] CH_RPAREN   = 8'h29;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_LANGLE   = 8'h3C;
   localparam logic [7:0] CH_EQUAL    = 8'h3D;
   localparam logic [7:0] CH_RANGLE   = 8'h3E;
   localparam logic [7:0] CH_AT       = 8'h40;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_UNDER    = 8'h5F;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;
   localparam logic [7:0] CASE_BIT    = 8'h20;

   // keyword spellings, right aligned, first letter highest
   localparam logic [63:0] KW_TEXT [NUM_KW] = '{
      "add", "alloca", "and", "ashr", "br", "bitcast", "call", "define",
      "default", "eq", "fadd", "fsub", "fmul", "fdiv", "fcmp", "false",
      "fptrunc", "fpext", "fptoui", "fptosi", "global", "gep", "icmp",
      "inbounds", "inttoptr", "load", "lshr", "module", "mul", "ne", "or",
      "oeq", "ogt", "oge", "olt", "ole", "one", "ord", "phi", "ptrtoint",
      "ret", "sub", "sdiv", "srem", "shl", "store", "switch", "sext",
      "sitofp", "sgt", "sge", "slt", "sle", "type", "trunc", "to", "true",
      "udiv", "urem", "uitofp", "ugt", "uge", "ult", "ule", "ueq", "une",
      "uno", "xor", "zext"
   };

   // one result token without its line
   typedef struct packed {
      logic [6:0]  token_kind;
      logic [63:0] int_magnitude;
      logic        minus_sign;
      logic [59:0] fraction_digits;
      logic [4:0]  fraction_count;
      logic [31:0] token_column;
      logic [31:0] text_start;
      logic [31:0] text_length;
   } token_type;

   // all tokens caused by one text byte
   typedef struct packed {
      logic [1:0]                 count;
      logic [31:0]                token_line;
      token_type [RUN_SLOTS-1:0]  tokens;
   } bundle_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   function automatic logic is_letter(input logic [7:0] c);
      logic [7:0] low;
      low = c | CASE_BIT;
      return (low >= CH_LOWER_A) && (low <= CH_LOWER_Z);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_name_start(input logic [7:0] c);
      return is_letter(c) || (c == CH_UNDER);
   endfunction

   function automatic logic is_name_byte(input logic [7:0] c);
      return is_name_start(c) || is_digit(c) || (c == CH_DOT);
   endfunction

   function automatic token_type simple_tok(input logic [6:0] kind,
                                            input logic [31:0] col);
      token_type t;
      t = '0;
      t.token_kind   = kind;
      t.token_column = col;
      return t;
   endfunction

   function automatic logic [6:0] punct_kind(input logic [7:0] c);
      logic [6:0] k;
      unique case (c)
         CH_EQUAL:    k = KIND_EQUAL;
         CH_COMMA:    k = KIND_COMMA;
         CH_COLON:    k = KIND_COLON;
         CH_LBRACE:   k = KIND_LBRACE;
         CH_RBRACE:   k = KIND_RBRACE;
         CH_LBRACKET: k = KIND_LBRACKET;
         CH_RBRACKET: k = KIND_RBRACKET;
         CH_LPAREN:   k = KIND_LPAREN;
         CH_RPAREN:   k = KIND_RPAREN;
         CH_LANGLE:   k = KIND_LANGLE;
         CH_RANGLE:   k = KIND_RANGLE;
         default:     k = KIND_ILLEGAL;
      endcase
      return k;
   endfunction

   function automatic int kw_len(input logic [63:0] s);
      int n;
      n = 0;
      for (int j = 0; j < KW_TEXT_BYTES; j++) begin
         if (s[8*j +: 8] != 8'h00) n++;
      end
      return n;
   endfunction

   // word holds the first name byte in its lowest byte
   function automatic logic [6:0] kw_lookup(input logic [63:0] word,
                                            input logic [3:0]  len);
      logic [6:0] kind;
      logic       hit;
      int         klen;
      kind = KIND_IDENT;
      for (int i = 0; i < NUM_KW; i++) begin
         klen = kw_len(KW_TEXT[i]);
         hit  = (len == 4'(klen));
         for (int j = 0; j < KW_TEXT_BYTES; j++) begin
            if (j < klen) begin
               if (word[8*j +: 8] != KW_TEXT[i][8*(klen-1-j) +: 8]) hit = 1'b0;
            end
         end
         if (hit) kind = 7'(KIND_KW_BASE + 7'(i));
      end
      return kind;
   endfunction

endpackage

// File: design/itt_channels.sv
// valid/ready channel interfaces for text bytes and result tokens
interface itt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

interface itt_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  token_kind;
   logic [63:0] int_magnitude;
   logic        minus_sign;
   logic [59:0] fraction_digits;
   logic [4:0]  fraction_count;
   logic [31:0] token_line;
   logic [31:0] token_column;
   logic [31:0] text_start;
   logic [31:0] text_length;
   logic        last_of_run;

   modport source (output valid, output token_kind, output int_magnitude,
                   output minus_sign, output fraction_digits, output fraction_count,
                   output token_line, output token_column, output text_start,
                   output text_length, output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input int_magnitude,
                   input minus_sign, input fraction_digits, input fraction_count,
                   input token_line, input token_column, input text_start,
                   input text_length, input last_of_run, output ready);
endinterface

// File: design/itt_front.sv
// scanner: classifies each byte, keeps scan state, builds token bundles
module itt_front #(
   parameter int KEYWORD_MAX_LEN     = 8,
   parameter int FRACTION_DIGITS_MAX = 18,
   parameter int POSITION_WIDTH      = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         text_byte,
   output logic               push,
   output itt_pkg::bundle_type bundle
);
   import itt_pkg::*;

   localparam int PW  = POSITION_WIDTH;
   localparam int KIW = $clog2(KEYWORD_MAX_LEN);

   typedef enum logic [11:0] {
      MODE_IDLE    = 12'b0000_0000_0001,
      MODE_COMMENT = 12'b0000_0000_0010,
      MODE_DOTS    = 12'b0000_0000_0100,
      MODE_GLOBAL  = 12'b0000_0000_1000,
      MODE_LOCAL   = 12'b0000_0001_0000,
      MODE_LABEL   = 12'b0000_0010_0000,
      MODE_STRING  = 12'b0000_0100_0000,
      MODE_IDENT   = 12'b0000_1000_0000,
      MODE_MINUS   = 12'b0001_0000_0000,
      MODE_INT     = 12'b0010_0000_0000,
      MODE_INT_DOT = 12'b0100_0000_0000,
      MODE_FRAC    = 12'b1000_0000_0000
   } scan_mode_type;

   scan_mode_type mode_ff, mode_in;
   logic [PW-1:0] offset_ff, offset_in;
   logic [PW-1:0] line_ff, line_in;
   logic [PW-1:0] row_base_ff, row_base_in;
   logic [PW-1:0] tok_start_ff, tok_start_in;
   logic [PW-1:0] tok_col_ff, tok_col_in;
   logic [PW-1:0] name_len_ff, name_len_in;
   logic [63:0]   int_acc_ff, int_acc_in;
   logic [59:0]   frac_acc_ff, frac_acc_in;
   logic [4:0]    frac_cnt_ff, frac_cnt_in;
   logic          minus_ff, minus_in;
   logic [1:0]    dots_ff, dots_in;
   logic [7:0]    kw_buf_ff [KEYWORD_MAX_LEN];

   logic          kw_we;
   logic [KIW-1:0] kw_idx;
   logic [7:0]    c;
   logic [3:0]    digit;
   logic [PW-1:0] col_p;
   logic [63:0]   kw_word;
   logic [3:0]    kw_len_short;
   logic [6:0]    kw_kind;
   logic [6:0]    sigil_kind;
   token_type     pre0, pre1, idle_tok;
   logic [1:0]    n_pre;
   logic          idle_has, do_idle, eof;

   assign c     = text_byte;
   assign digit = 4'(c - CH_ZERO);
   assign col_p = offset_ff - row_base_ff + PW'(1);

   // keyword match on the first bytes of the name
   always_comb begin
      for (int j = 0; j < KW_TEXT_BYTES; j++) kw_word[8*j +: 8] = kw_buf_ff[j];
   end
   assign kw_len_short = (name_len_ff <= PW'(KW_TEXT_BYTES)) ? 4'(name_len_ff) : 4'd0;
   assign kw_kind      = kw_lookup(kw_word, kw_len_short);

   always_comb begin
      if (mode_ff == MODE_GLOBAL)      sigil_kind = KIND_GLOBAL;
      else if (mode_ff == MODE_LOCAL)  sigil_kind = KIND_LOCAL;
      else                             sigil_kind = KIND_LABEL;
   end

   // next scan state and tokens for this byte
   always_comb begin
      mode_in       = mode_ff;
      offset_in     = offset_ff + PW'(1);
      line_in       = line_ff;
      row_base_in   = row_base_ff;
      tok_start_in  = tok_start_ff;
      tok_col_in    = tok_col_ff;
      name_len_in   = name_len_ff;
      int_acc_in    = int_acc_ff;
      frac_acc_in   = frac_acc_ff;
      frac_cnt_in   = frac_cnt_ff;
      minus_in      = minus_ff;
      dots_in       = dots_ff;
      kw_we         = 1'b0;
      kw_idx        = KIW'(name_len_ff);
      pre0          = '0;
      pre1          = '0;
      n_pre         = 2'd0;
      idle_tok      = '0;
      idle_has      = 1'b0;
      do_idle       = 1'b0;
      eof           = 1'b0;

      unique case (mode_ff)
         MODE_COMMENT: begin
            if (c == CH_LF || c == CH_NUL) do_idle = 1'b1;
         end
         MODE_DOTS: begin
            if (c == CH_DOT) begin
               if (dots_ff < 2'd2) begin
                  dots_in = 2'd2;
               end else begin
                  dots_in = 2'd0;
                  mode_in = MODE_IDLE;
                  pre0    = simple_tok(KIND_ELLIPSIS, 32'(tok_col_ff));
                  n_pre   = 2'd1;
               end
            end else begin
               pre0  = simple_tok(KIND_ILLEGAL, 32'(tok_col_ff));
               pre1  = simple_tok(KIND_ILLEGAL, 32'(tok_col_ff + PW'(1)));
               n_pre = (dots_ff >= 2'd2) ? 2'd2 : 2'd1;
               dots_in = 2'd0;
               do_idle = 1'b1;
            end
         end
         MODE_GLOBAL, MODE_LOCAL, MODE_LABEL: begin
            if (is_name_byte(c)) begin
               if (name_len_ff != '1) name_len_in = name_len_ff + PW'(1);
            end else begin
               if (name_len_ff == '0) begin
                  pre0 = simple_tok(KIND_ILLEGAL, 32'(tok_col_ff));
               end else begin
                  pre0 = simple_tok(sigil_kind, 32'(tok_col_ff));
                  pre0.text_start  = 32'(tok_start_ff);
                  pre0.text_length = 32'(name_len_ff);
               end
               n_pre   = 2'd1;
               do_idle = 1'b1;
            end
         end
         MODE_STRING: begin
            if (c == CH_QUOTE) begin
               pre0 = simple_tok(KIND_STRING, 32'(tok_col_ff));
               pre0.text_start  = 32'(tok_start_ff);
               pre0.text_length = 32'(name_len_ff);
               n_pre   = 2'd1;
               mode_in = MODE_IDLE;
            end else if (c == CH_NUL) begin
               pre0    = simple_tok(KIND_ILLEGAL, 32'(tok_col_ff));
               n_pre   = 2'd1;
               do_idle = 1'b1;
            end else if (name_len_ff != '1) begin
               name_len_in = name_len_ff + PW'(1);
            end
         end
         MODE_IDENT: begin
            if (is_name_byte(c)) begin
               kw_we = (name_len_ff < PW'(KEYWORD_MAX_LEN));
               if (name_len_ff != '1) name_len_in = name_len_ff + PW'(1);
            end else begin
               pre0 = simple_tok(kw_kind, 32'(tok_col_ff));
               if (kw_kind == KIND_IDENT) begin
                  pre0.text_start  = 32'(tok_start_ff);
                  pre0.text_length = 32'(name_len_ff);
               end
               n_pre   = 2'd1;
               do_idle = 1'b1;
            end
         end
         MODE_MINUS: begin
            if (is_digit(c)) begin
               mode_in     = MODE_INT;
               int_acc_in  = 64'(digit);
               frac_acc_in = '0;
               frac_cnt_in = '0;
               minus_in    = 1'b1;
            end else begin
               pre0    = simple_tok(KIND_ILLEGAL, 32'(tok_col_ff));
               n_pre   = 2'd1;
               do_idle = 1'b1;
            end
         end
         MODE_INT: begin
            if (is_digit(c)) begin
               int_acc_in = (int_acc_ff << 3) + (int_acc_ff << 1) + 64'(digit);
            end else if (c == CH_DOT) begin
               mode_in = MODE_INT_DOT;
            end else begin
               if (is_name_start(c)) begin
                  pre0 = simple_tok(KIND_ILLEGAL, 32'(tok_col_ff));
               end else begin
                  pre0 = simple_tok(KIND_INT, 32'(tok_col_ff));
                  pre0.int_magnitude = int_acc_ff;
                  pre0.minus_sign    = minus_ff;
               end
               n_pre   = 2'd1;
               do_idle = 1'b1;
            end
         end
         MODE_INT_DOT: begin
            if (is_digit(c)) begin
               mode_in     = MODE_FRAC;
               frac_acc_in = 60'(digit);
               frac_cnt_in = 5'd1;
            end else begin
               // integer closes, the dot restarts as a dot run
               pre0 = simple_tok(KIND_INT, 32'(tok_col_ff));
               pre0.int_magnitude = int_acc_ff;
               pre0.minus_sign    = minus_ff;
               tok_col_in = offset_ff - row_base_ff;
               if (c == CH_DOT) begin
                  mode_in = MODE_DOTS;
                  dots_in = 2'd2;
                  n_pre   = 2'd1;
               end else begin
                  pre1    = simple_tok(KIND_ILLEGAL, 32'(offset_ff - row_base_ff));
                  n_pre   = 2'd2;
                  dots_in = 2'd0;
                  do_idle = 1'b1;
               end
            end
         end
         MODE_FRAC: begin
            if (is_digit(c)) begin
               if (frac_cnt_ff < 5'(FRACTION_DIGITS_MAX)) begin
                  frac_acc_in = (frac_acc_ff << 3) + (frac_acc_ff << 1) + 60'(digit);
                  frac_cnt_in = frac_cnt_ff + 5'd1;
               end
            end else begin
               if (is_name_start(c)) begin
                  pre0 = simple_tok(KIND_ILLEGAL, 32'(tok_col_ff));
               end else begin
                  pre0 = simple_tok(KIND_FLOAT, 32'(tok_col_ff));
                  pre0.int_magnitude   = int_acc_ff;
                  pre0.minus_sign      = minus_ff;
                  pre0.fraction_digits = frac_acc_ff;
                  pre0.fraction_count  = frac_cnt_ff;
               end
               n_pre   = 2'd1;
               do_idle = 1'b1;
            end
         end
         default: do_idle = 1'b1;
      endcase

      // fresh scan of the byte between tokens
      if (do_idle) begin
         mode_in    = MODE_IDLE;
         tok_col_in = col_p;
         unique case (c)
            CH_SPACE, CH_TAB, CH_CR: begin
            end
            CH_LF: begin
               line_in     = line_ff + PW'(1);
               row_base_in = offset_ff + PW'(1);
            end
            CH_SEMI: mode_in = MODE_COMMENT;
            CH_NUL: begin
               idle_tok = simple_tok(KIND_EOF, 32'(col_p));
               idle_has = 1'b1;
               eof      = 1'b1;
            end
            CH_EQUAL, CH_COMMA, CH_COLON, CH_LBRACE, CH_RBRACE, CH_LBRACKET,
            CH_RBRACKET, CH_LPAREN, CH_RPAREN, CH_LANGLE, CH_RANGLE: begin
               idle_tok = simple_tok(punct_kind(c), 32'(col_p));
               idle_has = 1'b1;
            end
            CH_DOT: begin
               mode_in = MODE_DOTS;
               dots_in = 2'd1;
            end
            CH_AT, CH_PERCENT, CH_DOLLAR, CH_QUOTE: begin
               if (c == CH_AT)           mode_in = MODE_GLOBAL;
               else if (c == CH_PERCENT) mode_in = MODE_LOCAL;
               else if (c == CH_DOLLAR)  mode_in = MODE_LABEL;
               else                      mode_in = MODE_STRING;
               tok_start_in = offset_ff + PW'(1);
               name_len_in  = '0;
            end
            CH_MINUS: mode_in = MODE_MINUS;
            default: begin
               if (is_name_start(c)) begin
                  mode_in      = MODE_IDENT;
                  tok_start_in = offset_ff;
                  kw_we        = 1'b1;
                  kw_idx       = '0;
                  name_len_in  = PW'(1);
               end else if (is_digit(c)) begin
                  mode_in     = MODE_INT;
                  int_acc_in  = 64'(digit);
                  frac_acc_in = '0;
                  frac_cnt_in = '0;
                  minus_in    = 1'b0;
               end else begin
                  idle_tok = simple_tok(KIND_ILLEGAL, 32'(col_p));
                  idle_has = 1'b1;
               end
            end
         endcase
      end

      // end of text returns the scanner to its reset state
      if (eof) begin
         mode_in       = MODE_IDLE;
         offset_in     = '0;
         line_in       = PW'(1);
         row_base_in   = '0;
         tok_start_in  = '0;
         tok_col_in    = PW'(1);
         name_len_in   = '0;
         int_acc_in    = '0;
         frac_acc_in   = '0;
         frac_cnt_in   = '0;
         minus_in      = 1'b0;
         dots_in       = 2'd0;
      end
   end

   // pack the run of tokens into one bundle
   always_comb begin
      bundle            = '0;
      bundle.token_line = 32'(line_ff);
      bundle.count      = n_pre + 2'(idle_has);
      bundle.tokens[0]  = pre0;
      bundle.tokens[1]  = pre1;
      case (n_pre)
         2'd0:    bundle.tokens[0] = idle_tok;
         2'd1:    bundle.tokens[1] = idle_tok;
         default: bundle.tokens[2] = idle_tok;
      endcase
   end

   assign push = accept && (bundle.count != 2'd0);

   // scan state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         offset_ff     <= '0;
         line_ff       <= PW'(1);
         row_base_ff   <= '0;
         tok_start_ff  <= '0;
         tok_col_ff    <= PW'(1);
         name_len_ff   <= '0;
         int_acc_ff    <= '0;
         frac_acc_ff   <= '0;
         frac_cnt_ff   <= '0;
         minus_ff      <= 1'b0;
         dots_ff       <= 2'd0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         offset_ff     <= offset_in;
         line_ff       <= line_in;
         row_base_ff   <= row_base_in;
         tok_start_ff  <= tok_start_in;
         tok_col_ff    <= tok_col_in;
         name_len_ff   <= name_len_in;
         int_acc_ff    <= int_acc_in;
         frac_acc_ff   <= frac_acc_in;
         frac_cnt_ff   <= frac_cnt_in;
         minus_ff      <= minus_in;
         dots_ff       <= dots_in;
      end
   end

   // keyword buffer, only bytes below the name length are read
   always_ff @(posedge clock) begin
      if (accept && kw_we) kw_buf_ff[kw_idx] <= c;
   end

endmodule

// File: design/itt_queue.sv
// short queue of token bundles between scanner and output stage
module itt_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  itt_pkg::bundle_type     push_data,
   input  logic                    pop,
   output itt_pkg::bundle_type     head,
   output itt_pkg::queue_stat_type stat
);
   import itt_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   bundle_type     entry_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [AW:0]    fill_ff, fill_in;
   logic           do_push, do_pop;

   assign stat.full  = (fill_ff == (AW+1)'(DEPTH));
   assign stat.empty = (fill_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = entry_ff[rd_ptr_ff];

   // pointer and fill updates with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + AW'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + AW'(1);
      fill_in = fill_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// File: design/itt_back.sv
// output stage: walks each bundle and emits one token per transaction
module itt_back (
   input  logic                    clock,
   input  logic                    reset,
   input  itt_pkg::bundle_type     head,
   input  itt_pkg::queue_stat_type stat,
   output logic                    pop,
   itt_rsp_if.source               rsp_chan
);
   import itt_pkg::*;

   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   token_type   tok_ff, tok_in;
   logic [31:0] line_ff, line_in;
   logic        last_ff, last_in;
   logic        load, last_slot;

   assign load      = !valid_ff || rsp_chan.ready;
   assign last_slot = (idx_ff == head.count - 2'd1);

   // pick the next token of the head bundle into the output register
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      tok_in   = tok_ff;
      line_in  = line_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = !stat.empty;
         if (!stat.empty) begin
            tok_in  = head.tokens[idx_ff];
            line_in = head.token_line;
            last_in = last_slot;
            pop     = last_slot;
            idx_in  = last_slot ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      line_ff <= line_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.token_kind      = tok_ff.token_kind;
   assign rsp_chan.int_magnitude   = tok_ff.int_magnitude;
   assign rsp_chan.minus_sign      = tok_ff.minus_sign;
   assign rsp_chan.fraction_digits = tok_ff.fraction_digits;
   assign rsp_chan.fraction_count  = tok_ff.fraction_count;
   assign rsp_chan.token_line      = line_ff;
   assign rsp_chan.token_column    = tok_ff.token_column;
   assign rsp_chan.text_start      = tok_ff.text_start;
   assign rsp_chan.text_length     = tok_ff.text_length;
   assign rsp_chan.last_of_run     = last_ff;

endmodule

// File: design/ir_text_tokenizer.sv
// top level of the text tokenizer: scanner, bundle queue, output stage
// the bundle of an accepted byte is written into the queue; its first token then loads into the output register
// throughput: one byte per cycle while the queue has room; the tokens of one byte leave one at a time,
//    through the single output register that drains the bundle queue
// the scanner keeps taking bytes while the queue (4 bundles) has room
// reset is synchronous: scan state, queue and output valid clear; an end-of-text
//    byte returns the scan state to its reset values
module ir_text_tokenizer #(
   parameter int KEYWORD_MAX_LEN     = itt_pkg::KEYWORD_MAX_LEN_DEF,
   parameter int FRACTION_DIGITS_MAX = itt_pkg::FRACTION_DIGITS_MAX_DEF,
   parameter int POSITION_WIDTH      = itt_pkg::POSITION_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   itt_req_if.sink    req_chan,
   itt_rsp_if.source  rsp_chan
);
   import itt_pkg::*;

   logic           accept, push, pop;
   bundle_type     push_data, head;
   queue_stat_type stat;

   // a byte is taken whenever the queue can hold its bundle
   assign req_chan.ready = !stat.full;
   assign accept         = req_chan.valid && req_chan.ready;

   itt_front #(
      .KEYWORD_MAX_LEN     (KEYWORD_MAX_LEN),
      .FRACTION_DIGITS_MAX (FRACTION_DIGITS_MAX),
      .POSITION_WIDTH      (POSITION_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_byte (req_chan.text_byte),
      .push      (push),
      .bundle    (push_data)
   );

   itt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .stat      (stat)
   );

   itt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .stat     (stat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: design/itt_checker.sv
// port-level checks of the tokenizer, bound to the top level
`include "ir_text_tokenizer_macros.svh"

module itt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [6:0]  token_kind,
   input logic [63:0] int_magnitude,
   input logic        minus_sign,
   input logic [4:0]  fraction_count,
   input logic        last_of_run
);
   import itt_pkg::*;

   // a stalled token keeps its kind and value
   `ITT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(token_kind) && $stable(int_magnitude), "stalled token changed")

   // nothing is offered right after reset
   `ITT_ASSERT_NEXT_ALWAYS(a_reset_idle, reset, !rsp_valid, "token offered after reset")

   // end of text closes its run
   `ITT_ASSERT_NOW(a_eof_last, rsp_valid && token_kind == KIND_EOF, last_of_run, "eof not last of run")

   // number fields stay clear outside number tokens
   `ITT_ASSERT_NOW(a_num_clear, rsp_valid && token_kind != KIND_INT && token_kind != KIND_FLOAT, int_magnitude == '0 && !minus_sign && fraction_count == '0, "number fields set on non-number")

endmodule

bind ir_text_tokenizer itt_checker u_itt_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .token_kind     (rsp_chan.token_kind),
   .int_magnitude  (rsp_chan.int_magnitude),
   .minus_sign     (rsp_chan.minus_sign),
   .fraction_count (rsp_chan.fraction_count),
   .last_of_run    (rsp_chan.last_of_run)
);

// File: tb/ir_text_tokenizer_test.sv
// self-checking testbench of the text tokenizer: directed texts, then random text
module ir_text_tokenizer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import itt_pkg::*;

   // scanner states of the token predictor
   typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_COMMENT, SCAN_DOTS, SCAN_GLOBAL, SCAN_LOCAL, SCAN_LABEL,
      SCAN_STRING, SCAN_IDENT, SCAN_MINUS, SCAN_INT, SCAN_INT_DOT, SCAN_FRAC
   } scan_state_type;

   // one token as seen on the result channel
   typedef struct {
      logic [6:0]  kind;
      logic [63:0] mag;
      logic        neg;
      logic [59:0] frac;
      logic [4:0]  fcnt;
      logic [31:0] line;
      logic [31:0] col;
      logic [31:0] tstart;
      logic [31:0] tlen;
      logic        last;
   } exp_token_type;

   localparam int KEYWORD_LIMIT  = 8;
   localparam int FRACTION_LIMIT = 18;
   localparam int STALL_LIMIT    = 3000;
   localparam int RANDOM_BYTES   = 270;

   localparam string KEYWORDS [NUM_KW] = '{
      "add", "alloca", "and", "ashr", "br", "bitcast", "call", "define",
      "default", "eq", "fadd", "fsub", "fmul", "fdiv", "fcmp", "false",
      "fptrunc", "fpext", "fptoui", "fptosi", "global", "gep", "icmp",
      "inbounds", "inttoptr", "load", "lshr", "module", "mul", "ne", "or",
      "oeq", "ogt", "oge", "olt", "ole", "one", "ord", "phi", "ptrtoint",
      "ret", "sub", "sdiv", "srem", "shl", "store", "switch", "sext",
      "sitofp", "sgt", "sge", "slt", "sle", "type", "trunc", "to", "true",
      "udiv", "urem", "uitofp", "ugt", "uge", "ult", "ule", "ueq", "une",
      "uno", "xor", "zext"
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   calm  = 1'b0;
   int   errors = 0;
   int   quiet_cycles = 0;

   itt_req_if req_chan ();
   itt_rsp_if rsp_chan ();

   ir_text_tokenizer uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #2 clock = ~clock;

   // predictor state
   scan_state_type scan;
   logic [31:0] offset, line_no, row_base, tok_start, tok_col, name_len;
   logic [7:0]  word_buf [KEYWORD_LIMIT];
   logic [63:0] int_acc;
   logic [59:0] frac_acc;
   logic [4:0]  frac_cnt;
   logic        minus;
   logic [1:0]  dots;
   bit          hit_eof;
   exp_token_type run_tokens [$];
   exp_token_type pending_tokens [$];

   function automatic bit letter(logic [7:0] c);
      return ((c | 8'h20) >= "a") && ((c | 8'h20) <= "z");
   endfunction

   function automatic bit digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic bit name_first(logic [7:0] c);
      return letter(c) || (c == "_");
   endfunction

   function automatic bit name_char(logic [7:0] c);
      return name_first(c) || digit(c) || (c == ".");
   endfunction

   function automatic void clear_scanner();
      scan = SCAN_IDLE;
      offset = 0;
      line_no = 1;
      row_base = 0;
      tok_start = 0;
      tok_col = 1;
      name_len = 0;
      int_acc = 0;
      frac_acc = 0;
      frac_cnt = 0;
      minus = 0;
      dots = 0;
   endfunction

   function automatic void emit(logic [6:0] kind, logic [31:0] col,
                                logic [63:0] mag = 0, logic neg = 0, logic [59:0] frac = 0,
                                logic [4:0] fcnt = 0, logic [31:0] ts = 0,
                                logic [31:0] tl = 0);
      exp_token_type t;
      t = '{kind, mag, neg, frac, fcnt, line_no, col, ts, tl, 1'b0};
      run_tokens.push_back(t);
   endfunction

   function automatic logic [6:0] word_kind();
      bit same;
      for (int i = 0; i < NUM_KW; i++) begin
         if (KEYWORDS[i].len() == name_len && name_len <= KEYWORD_LIMIT) begin
            same = 1;
            for (int j = 0; j < KEYWORDS[i].len(); j++)
               if (word_buf[j] != KEYWORDS[i][j]) same = 0;
            if (same) return KIND_KW_BASE + 7'(i);
         end
      end
      return KIND_IDENT;
   endfunction

   function automatic void grow();
      if (name_len != 32'hFFFF_FFFF) name_len++;
   endfunction

   // byte seen between tokens
   function automatic void scan_fresh(logic [7:0] c, logic [31:0] p);
      logic [31:0] col;
      col = p - row_base + 1;
      scan = SCAN_IDLE;
      tok_col = col;
      case (c)
         CH_SPACE, CH_TAB, CH_CR: ;
         CH_LF: begin
            line_no++;
            row_base = p + 1;
         end
         CH_SEMI: scan = SCAN_COMMENT;
         CH_NUL: begin
            emit(KIND_EOF, col);
            hit_eof = 1;
         end
         CH_EQUAL:    emit(KIND_EQUAL, col);
         CH_COMMA:    emit(KIND_COMMA, col);
         CH_COLON:    emit(KIND_COLON, col);
         CH_LBRACE:   emit(KIND_LBRACE, col);
         CH_RBRACE:   emit(KIND_RBRACE, col);
         CH_LBRACKET: emit(KIND_LBRACKET, col);
         CH_RBRACKET: emit(KIND_RBRACKET, col);
         CH_LPAREN:   emit(KIND_LPAREN, col);
         CH_RPAREN:   emit(KIND_RPAREN, col);
         CH_LANGLE:   emit(KIND_LANGLE, col);
         CH_RANGLE:   emit(KIND_RANGLE, col);
         CH_DOT: begin
            scan = SCAN_DOTS;
            dots = 1;
         end
         CH_AT, CH_PERCENT, CH_DOLLAR, CH_QUOTE: begin
            scan = (c == CH_AT) ? SCAN_GLOBAL : (c == CH_PERCENT) ? SCAN_LOCAL :
                   (c == CH_DOLLAR) ? SCAN_LABEL : SCAN_STRING;
            tok_start = p + 1;
            name_len = 0;
         end
         CH_MINUS: scan = SCAN_MINUS;
         default: begin
            if (name_first(c)) begin
               scan = SCAN_IDENT;
               tok_start = p;
               word_buf[0] = c;
               name_len = 1;
            end else if (digit(c)) begin
               scan = SCAN_INT;
               int_acc = 64'(c - CH_ZERO);
               frac_acc = 0;
               frac_cnt = 0;
               minus = 0;
            end else begin
               emit(KIND_ILLEGAL, col);
            end
         end
      endcase
   endfunction

   function automatic void scan_dots(logic [7:0] c, logic [31:0] p);
      if (c == CH_DOT) begin
         if (dots < 2) begin
            dots = 2;
         end else begin
            dots = 0;
            scan = SCAN_IDLE;
            emit(KIND_ELLIPSIS, tok_col);
         end
      end else begin
         emit(KIND_ILLEGAL, tok_col);
         if (dots >= 2) emit(KIND_ILLEGAL, tok_col + 1);
         dots = 0;
         scan_fresh(c, p);
      end
   endfunction

   function automatic void close_number(logic [7:0] c, bit with_frac);
      if (name_first(c)) emit(KIND_ILLEGAL, tok_col);
      else if (with_frac) emit(KIND_FLOAT, tok_col, int_acc, minus, frac_acc, frac_cnt);
      else emit(KIND_INT, tok_col, int_acc, minus);
   endfunction

   // tokens caused by one text byte, queued as expectations
   function automatic void predict_tokens(logic [7:0] c);
      logic [31:0] p;
      logic [6:0]  k;
      p = offset;
      hit_eof = 0;
      run_tokens.delete();
      case (scan)
         SCAN_COMMENT: if (c == CH_LF || c == CH_NUL) scan_fresh(c, p);
         SCAN_DOTS: scan_dots(c, p);
         SCAN_GLOBAL, SCAN_LOCAL, SCAN_LABEL: begin
            if (name_char(c)) begin
               grow();
            end else begin
               k = (scan == SCAN_GLOBAL) ? KIND_GLOBAL :
                   (scan == SCAN_LOCAL) ? KIND_LOCAL : KIND_LABEL;
               if (name_len == 0) emit(KIND_ILLEGAL, tok_col);
               else emit(k, tok_col, 0, 0, 0, 0, tok_start, name_len);
               scan_fresh(c, p);
            end
         end
         SCAN_STRING: begin
            if (c == CH_QUOTE) begin
               emit(KIND_STRING, tok_col, 0, 0, 0, 0, tok_start, name_len);
               scan = SCAN_IDLE;
            end else if (c == CH_NUL) begin
               emit(KIND_ILLEGAL, tok_col);
               scan_fresh(c, p);
            end else begin
               grow();
            end
         end
         SCAN_IDENT: begin
            if (name_char(c)) begin
               if (name_len < KEYWORD_LIMIT) word_buf[name_len] = c;
               grow();
            end else begin
               k = word_kind();
               if (k == KIND_IDENT) emit(KIND_IDENT, tok_col, 0, 0, 0, 0, tok_start, name_len);
               else emit(k, tok_col);
               scan_fresh(c, p);
            end
         end
         SCAN_MINUS: begin
            if (digit(c)) begin
               scan = SCAN_INT;
               int_acc = 64'(c - CH_ZERO);
               frac_acc = 0;
               frac_cnt = 0;
               minus = 1;
            end else begin
               emit(KIND_ILLEGAL, tok_col);
               scan_fresh(c, p);
            end
         end
         SCAN_INT: begin
            if (digit(c)) int_acc = int_acc * 10 + 64'(c - CH_ZERO);
            else if (c == CH_DOT) scan = SCAN_INT_DOT;
            else begin
               close_number(c, 0);
               scan_fresh(c, p);
            end
         end
         SCAN_INT_DOT: begin
            if (digit(c)) begin
               scan = SCAN_FRAC;
               frac_acc = 60'(c - CH_ZERO);
               frac_cnt = 1;
            end else begin
               close_number(CH_DOT, 0);
               scan = SCAN_DOTS;
               dots = 1;
               tok_col = p - row_base;
               scan_dots(c, p);
            end
         end
         SCAN_FRAC: begin
            if (digit(c)) begin
               if (frac_cnt < FRACTION_LIMIT) begin
                  frac_acc = frac_acc * 10 + 60'(c - CH_ZERO);
                  frac_cnt++;
               end
            end else begin
               close_number(c, 1);
               scan_fresh(c, p);
            end
         end
         default: scan_fresh(c, p);
      endcase
      if (hit_eof) clear_scanner();
      else offset = p + 1;
      if (run_tokens.size() > 0) run_tokens[run_tokens.size()-1].last = 1;
      foreach (run_tokens[i]) pending_tokens.push_back(run_tokens[i]);
   endfunction

   // sends one text byte, with a random idle burst in front
   task automatic send_byte(logic [7:0] c);
      int gap;
      gap = (!calm && $urandom_range(0, 9) == 0) ? $urandom_range(1, 18) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.text_byte <= c;
      do @(posedge clock); while (!req_chan.ready);
      predict_tokens(c);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // punctuation, ellipsis, comments and line counting
   task automatic test_punctuation();
      send_text("=,:{}[]()<>...; c\n\t\r");
   endtask

   // number extremes: wrap, long fraction, minus, dot after integer
   task automatic test_numbers();
      send_text("-99999999999999999999 1.12345678901234567890 7. 3x -a ");
   endtask

   // names, keywords, strings and unknown bytes
   task automatic test_names();
      send_text("@g.1 %l $ inttoptr ptrtoint inbounds add addx \"s\n\"");
      send_byte(8'hFF);
      send_byte(8'h01);
      send_text(". .. x\"open");
      send_byte(CH_NUL);
   endtask

   // random text mostly made of well-formed tokens
   task automatic test_random_text();
      logic [7:0] frag [$];
      int sent, n, w;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         frag.delete();
         case ($urandom_range(0, 11))
            0, 1: begin
               w = $urandom_range(0, NUM_KW - 1);
               for (int j = 0; j < KEYWORDS[w].len(); j++) frag.push_back(KEYWORDS[w][j]);
            end
            2: begin
               n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 5);
               frag.push_back("_");
               repeat (n) frag.push_back($urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                                               : 8'("0" + $urandom_range(0, 9)));
            end
            3: begin
               case ($urandom_range(0, 2))
                  0: frag.push_back(CH_AT);
                  1: frag.push_back(CH_PERCENT);
                  default: frag.push_back(CH_DOLLAR);
               endcase
               repeat ($urandom_range(0, 4)) frag.push_back(8'("a" + $urandom_range(0, 25)));
            end
            4, 5: begin
               if ($urandom_range(0, 2) == 0) frag.push_back(CH_MINUS);
               n = ($urandom_range(0, 6) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 4);
               repeat (n) frag.push_back(8'("0" + $urandom_range(0, 9)));
               if ($urandom_range(0, 1)) begin
                  frag.push_back(CH_DOT);
                  n = ($urandom_range(0, 6) == 0) ? $urandom_range(17, 22) : $urandom_range(0, 3);
                  repeat (n) frag.push_back(8'("0" + $urandom_range(0, 9)));
               end
            end
            6: begin
               frag.push_back(CH_QUOTE);
               repeat ($urandom_range(0, 5)) frag.push_back(8'($urandom_range(1, 255)));
               frag.push_back(CH_QUOTE);
            end
            7: begin
               frag.push_back(CH_SEMI);
               repeat ($urandom_range(0, 4)) frag.push_back(8'($urandom_range(1, 255)));
               frag.push_back(CH_LF);
            end
            8: repeat ($urandom_range(1, 3)) frag.push_back(CH_DOT);
            9: frag.push_back(8'($urandom_range(0, 255)));
            10: frag.push_back($urandom_range(0, 15) == 0 ? CH_NUL : CH_LF);
            default: begin
               case ($urandom_range(0, 10))
                  0: frag.push_back(CH_EQUAL);
                  1: frag.push_back(CH_COMMA);
                  2: frag.push_back(CH_COLON);
                  3: frag.push_back(CH_LBRACE);
                  4: frag.push_back(CH_RBRACE);
                  5: frag.push_back(CH_LBRACKET);
                  6: frag.push_back(CH_RBRACKET);
                  7: frag.push_back(CH_LPAREN);
                  8: frag.push_back(CH_RPAREN);
                  9: frag.push_back(CH_LANGLE);
                  default: frag.push_back(CH_RANGLE);
               endcase
            end
         endcase
         if ($urandom_range(0, 2) != 0) frag.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
         foreach (frag[i]) send_byte(frag[i]);
         sent += frag.size();
         if (sent > RANDOM_BYTES * 4 / 5) calm = 1;
      end
      send_byte(CH_NUL);
   endtask

   // receiver stalls in random bursts
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   function automatic void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s: expected %0h actual %0h", $realtime, field, want, got);
         errors++;
      end
   endfunction

   // checks each result transaction against the oldest expected token
   always @(posedge clock) begin
      exp_token_type t;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_tokens.size() == 0) begin
            $display("%0t unexpected token: expected none actual kind %0d",
                     $realtime, rsp_chan.token_kind);
            errors++;
         end else begin
            t = pending_tokens.pop_front();
            compare("token_kind", t.kind, rsp_chan.token_kind);
            compare("int_magnitude", t.mag, rsp_chan.int_magnitude);
            compare("minus_sign", t.neg, rsp_chan.minus_sign);
            compare("fraction_digits", t.frac, rsp_chan.fraction_digits);
            compare("fraction_count", t.fcnt, rsp_chan.fraction_count);
            compare("token_line", t.line, rsp_chan.token_line);
            compare("token_column", t.col, rsp_chan.token_column);
            compare("text_start", t.tstart, rsp_chan.text_start);
            compare("text_length", t.tlen, rsp_chan.text_length);
            compare("last_of_run", t.last, rsp_chan.last_of_run);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.text_byte = 8'h00;
      rsp_chan.ready     = 1'b1;
      clear_scanner();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_punctuation();
      test_numbers();
      test_names();
      test_random_text();
      req_chan.valid <= 1'b0;
      while (pending_tokens.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
